FILE: rtl/vertex_pair_deduplicator_defines.svh
// assertion macros shared by the vertex pair deduplicator rtl
`ifndef VERTEX_PAIR_DEDUPLICATOR_DEFINES_SVH
`define VERTEX_PAIR_DEDUPLICATOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define VPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define VPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vpd_pkg.sv
// package: sizes and shared types of the vertex pair deduplicator
package vpd_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int N_CELLS     = 4;
  localparam int CELL_W      = $clog2(N_CELLS);
  localparam int ROWS        = (TABLE_DEPTH + N_CELLS - 1) / N_CELLS;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W      = ROW_W + CELL_W;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W       = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = 16;
  localparam int FINAL_W     = 12;
  localparam int UCNT_W      = 13;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [CELL_W-1:0] wr_cell;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
  } cell_cmd_t;

  // search result handed from cell to cell
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } chain_t;

endpackage

FILE: rtl/vertex_pair_deduplicator.sv
// top level: vertex pair deduplicator with a chain of search cells
// Each input transaction carries one triangle corner (position and texcoord index); the block
// answers with the slot of the earliest equal pair in its table, or appends the pair as a new
// slot. The table is split across a row of four cells, each owning one ram bank; a search
// reads one row of four slots at a time, each row passing a read state and then a compare
// through the cell chain; it stops at a hit or the last stored row, and skips an empty table.
// A full table holds 4096 pairs. One corner is in work at a time; the result register lets
// a new corner be accepted while the previous result still waits on the output side. No
// clearing pass is needed after reset.
`include "vertex_pair_deduplicator_defines.svh"

module vertex_pair_deduplicator
  import vpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // corner input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] position_index, [31:16] texcoord_index
  input  logic [31:0] s_axis_tdata_i,
  // [0] start_new
  input  logic        s_axis_tuser_i,
  // result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [11:0] final_index, [12] is_new, [13] overflow, [26:14] unique_count, [31:27] zero
  output logic [31:0] m_axis_tdata_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_RESOLVE
  } state_e;

  state_e state_q, state_d;

  // search context
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              hit_q, hit_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  // result register
  logic               m_valid_q, m_valid_d;
  logic [FINAL_W-1:0] res_index_q, res_index_d;
  logic               res_new_q, res_new_d;
  logic               res_ovf_q, res_ovf_d;
  logic [UCNT_W-1:0]  res_cnt_q, res_cnt_d;

  cell_cmd_t         cmd;
  chain_t            chain [N_CELLS+1];
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  count_inc;
  logic [ROW_W-1:0]  last_row;
  logic              out_free;
  logic              in_txn;

  assign in_txn    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign count_eff = s_axis_tuser_i ? '0 : count_q;
  assign count_inc = count_q + CNT_W'(1);
  // last row holding a stored slot, only looked at while count_q is nonzero
  assign last_row  = ROW_W'((count_q - CNT_W'(1)) >> CELL_W);

  // cell command broadcast
  always_comb begin
    cmd.rd_en   = (state_q == ST_READ);
    cmd.rd_row  = row_q;
    cmd.wr_en   = (state_q == ST_RESOLVE) && out_free && !hit_q &&
                  (CMP_W'(count_q) < CMP_W'(TABLE_DEPTH));
    cmd.wr_row  = ROW_W'(count_q >> CELL_W);
    cmd.wr_cell = count_q[CELL_W-1:0];
    cmd.key     = key_q;
    cmd.count   = count_q;
  end

  assign chain[0] = '{hit: 1'b0, slot: '0};

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    vpd_cell u_cell (
      .clk_i     (clk_i),
      .cell_idx_i(CELL_W'(g)),
      .cmd_i     (cmd),
      .chain_i   (chain[g]),
      .chain_o   (chain[g+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    count_d     = count_q;
    row_d       = row_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    m_valid_d   = m_valid_q;
    res_index_d = res_index_q;
    res_new_d   = res_new_q;
    res_ovf_d   = res_ovf_q;
    res_cnt_d   = res_cnt_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_txn) begin
          // table key: position in the upper half, texcoord in the lower half
          key_d   = {s_axis_tdata_i[IDX_W-1:0], s_axis_tdata_i[2*IDX_W-1:IDX_W]};
          count_d = count_eff;
          row_d   = '0;
          hit_d   = 1'b0;
          state_d = (count_eff == '0) ? ST_RESOLVE : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (chain[N_CELLS].hit) begin
          hit_d   = 1'b1;
          slot_d  = chain[N_CELLS].slot;
          state_d = ST_RESOLVE;
        end else if (row_q == last_row) begin
          state_d = ST_RESOLVE;
        end else begin
          row_d   = row_q + ROW_W'(1);
          state_d = ST_READ;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
          if (hit_q) begin
            res_index_d = FINAL_W'(slot_q);
            res_new_d   = 1'b0;
            res_ovf_d   = 1'b0;
            res_cnt_d   = UCNT_W'(count_q);
          end else if (CMP_W'(count_q) < CMP_W'(TABLE_DEPTH)) begin
            // append at the next free slot
            res_index_d = FINAL_W'(count_q);
            res_new_d   = 1'b1;
            res_ovf_d   = 1'b0;
            res_cnt_d   = UCNT_W'(count_inc);
            count_d     = count_inc;
          end else begin
            // table full and pair unseen
            res_index_d = '0;
            res_new_d   = 1'b0;
            res_ovf_d   = 1'b1;
            res_cnt_d   = UCNT_W'(count_q);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_q       <= '0;
      count_q     <= '0;
      row_q       <= '0;
      hit_q       <= 1'b0;
      slot_q      <= '0;
      m_valid_q   <= 1'b0;
      res_index_q <= '0;
      res_new_q   <= 1'b0;
      res_ovf_q   <= 1'b0;
      res_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      count_q     <= count_d;
      row_q       <= row_d;
      hit_q       <= hit_d;
      slot_q      <= slot_d;
      m_valid_q   <= m_valid_d;
      res_index_q <= res_index_d;
      res_new_q   <= res_new_d;
      res_ovf_q   <= res_ovf_d;
      res_cnt_q   <= res_cnt_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, res_cnt_q, res_ovf_q, res_new_q, res_index_q};

  // stored count never passes the table depth
  `VPD_ASSERT_NOW(a_count_bound, 1'b1, CMP_W'(count_q) <= CMP_W'(TABLE_DEPTH), "count over depth")
  // a row is only read when something is stored
  `VPD_ASSERT_NOW(a_read_nonempty, state_q == ST_READ, count_q != '0, "read of empty table")
  // a start flag empties the table for this corner
  `VPD_ASSERT_NEXT(a_start_clears, in_txn && s_axis_tuser_i, count_q == '0, "start not cleared")
  // overflow is only reported with a full table
  `VPD_ASSERT_NOW(a_ovf_full, m_valid_q && res_ovf_q,
                  res_cnt_q == UCNT_W'(TABLE_DEPTH) && !res_new_q, "overflow not full")

endmodule

FILE: rtl/vpd_ram.sv
// generic single-write, single-read ram with registered read data
module vpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/vpd_cell.sv
// search cell: one bank of the pair table, compare and priority hand-off
module vpd_cell
  import vpd_pkg::*;
(
  input  logic              clk_i,
  input  logic [CELL_W-1:0] cell_idx_i,
  input  cell_cmd_t         cmd_i,
  input  chain_t            chain_i,
  output chain_t            chain_o
);

  logic [KEY_W-1:0]  entry;
  logic [SLOT_W-1:0] my_slot;
  logic              in_use;
  logic              match;

  vpd_ram #(
    .WIDTH(KEY_W),
    .DEPTH(ROWS)
  ) u_bank (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.wr_en && (cmd_i.wr_cell == cell_idx_i)),
    .wr_addr_i(cmd_i.wr_row),
    .wr_data_i(cmd_i.key),
    .rd_en_i  (cmd_i.rd_en),
    .rd_addr_i(cmd_i.rd_row),
    .rd_data_o(entry)
  );

  // slot number of this cell within the row under compare
  assign my_slot = {cmd_i.rd_row, cell_idx_i};
  assign in_use  = CMP_W'(my_slot) < CMP_W'(cmd_i.count);
  assign match   = in_use && (entry == cmd_i.key);

  // an earlier cell's hit wins
  always_comb begin
    chain_o.hit  = chain_i.hit | match;
    chain_o.slot = chain_i.hit ? chain_i.slot : my_slot;
  end

endmodule

FILE: tb/sv/tb.sv
// testbench top: stream-driven check of the vertex pair deduplicator against a table predictor
module tb;
  import vpd_pkg::*;

  // run length bound checked by the watchdog
  localparam int unsigned      CYCLE_LIMIT  = 200_000;
  localparam int               RANDOM_ITEMS = 120;
  localparam int               POOL_SIZE    = 6;
  localparam int               DRAIN_CYCLES = 16;

  // one answer of the block, field by field
  typedef struct packed {
    logic [FINAL_W-1:0] final_index;
    logic               is_new;
    logic               overflow;
    logic [UCNT_W-1:0]  unique_count;
  } corner_result_t;

  // one line of the directed stimulus
  typedef struct packed {
    bit                 start;
    logic [IDX_W-1:0]   pos;
    logic [IDX_W-1:0]   tc;
    bit                 typed;
    corner_result_t     res;
  } corner_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_data;
  logic        in_user;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [31:0] res_data;

  // predictor state: the distinct pairs in order of first appearance
  logic [KEY_W-1:0] pair_keys [TABLE_DEPTH];
  int unsigned      pairs_held;

  corner_result_t   expected_q [$];
  corner_row_t      dir_rows [$];

  int unsigned cycle_count;
  int          errors;
  int          corners_sent;
  int          results_seen;
  int          new_seen;
  int          hit_seen;
  int          overflow_seen;
  int          res_wait = 0;
  bit          quiet_mode;
  corner_result_t got_res;
  corner_result_t want_res;

  vertex_pair_deduplicator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    // [15:0] position_index, [31:16] texcoord_index
    .s_axis_tdata_i  (in_data),
    // [0] start_new
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    // [11:0] final_index, [12] is_new, [13] overflow, [26:14] unique_count, [31:27] zero
    .m_axis_tdata_o  (res_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s at result %0d: got %0d, want %0d", what, results_seen, got, want);
    errors++;
  endtask

  // table behavior: optional clear, earliest-match search, append or overflow
  function automatic corner_result_t predict_corner(input bit start, input logic [IDX_W-1:0] pos,
                                                    input logic [IDX_W-1:0] tc);
    corner_result_t r;
    logic [KEY_W-1:0] key;
    bit found;
    int unsigned slot;
    r     = '0;
    key   = {pos, tc};
    found = 1'b0;
    slot  = 0;
    if (start) begin
      pairs_held = 0;
    end
    for (int unsigned i = 0; i < pairs_held && !found; i++) begin
      if (pair_keys[i] == key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (!found) begin
      if (pairs_held < TABLE_DEPTH) begin
        slot = pairs_held;
        pair_keys[slot] = key;
        pairs_held++;
        r.is_new = 1'b1;
      end else begin
        slot       = 0;
        r.overflow = 1'b1;
      end
    end
    r.final_index  = FINAL_W'(slot);
    r.unique_count = UCNT_W'(pairs_held);
    return r;
  endfunction

  function automatic corner_result_t known_result(input int slot, input bit is_new,
                                                  input bit overflow, input int count);
    corner_result_t r;
    r.final_index  = FINAL_W'(slot);
    r.is_new       = is_new;
    r.overflow     = overflow;
    r.unique_count = UCNT_W'(count);
    return r;
  endfunction

  function automatic corner_row_t corner_row(input bit start, input logic [IDX_W-1:0] pos,
                                             input logic [IDX_W-1:0] tc, input bit typed,
                                             input corner_result_t res);
    corner_row_t row;
    row.start = start;
    row.pos   = pos;
    row.tc    = tc;
    row.typed = typed;
    row.res   = res;
    return row;
  endfunction

  // append one line to the directed table
  function automatic void add_row(input corner_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // one input transaction: random gap, then hold valid until the block takes it
  task automatic send_corner(input bit start, input logic [IDX_W-1:0] pos,
                             input logic [IDX_W-1:0] tc, input bit typed,
                             input corner_result_t typed_res);
    int gap;
    corner_result_t r;
    corner_result_t want;
    gap = quiet_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {tc, pos};
    in_user  <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // predictor always runs so its table tracks the block, even on typed rows
    r    = predict_corner(start, pos, tc);
    want = typed ? typed_res : r;
    expected_q = {expected_q, want};
    corners_sent++;
  endtask

  // hold off the sender until every pending result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // result side: check each accepted transaction, then draw a stall for the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_ready && res_valid) begin
        got_res.final_index  = res_data[11:0];
        got_res.is_new       = res_data[12];
        got_res.overflow     = res_data[13];
        got_res.unique_count = res_data[26:14];
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending", res_data, 0);
        end else begin
          want_res = expected_q.pop_front();
          if (got_res.final_index != want_res.final_index)
            report_mismatch("final_index", int'(got_res.final_index),
                            int'(want_res.final_index));
          if (got_res.is_new != want_res.is_new)
            report_mismatch("is_new", int'(got_res.is_new), int'(want_res.is_new));
          if (got_res.overflow != want_res.overflow)
            report_mismatch("overflow", int'(got_res.overflow), int'(want_res.overflow));
          if (got_res.unique_count != want_res.unique_count)
            report_mismatch("unique_count", int'(got_res.unique_count),
                            int'(want_res.unique_count));
        end
        if (got_res.overflow) overflow_seen++;
        else if (got_res.is_new) new_seen++;
        else hit_seen++;
        results_seen++;
        res_wait = quiet_mode ? 0 : $urandom_range(0, 6);
      end else if (res_wait > 0) begin
        res_wait--;
      end
      res_ready <= (res_wait == 0);
    end
  end

  initial begin
    logic [IDX_W-1:0] pos_pool [POOL_SIZE];
    logic [IDX_W-1:0] tc_pool [POOL_SIZE];
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] tc;
    int random_sent;
    int mesh_len;
    bit start;
    bit first_mesh;

    // every input known from time zero
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    in_user    = 1'b0;
    quiet_mode = 1'b0;
    pairs_held = 0;

    // directed part: extremes, hits, swapped halves, clears
    add_row(corner_row(1'b0, 16'h0000, 16'h0000, 1'b1, known_result(0, 1'b1, 1'b0, 1)));
    add_row(corner_row(1'b0, 16'hffff, 16'hffff, 1'b1, known_result(1, 1'b1, 1'b0, 2)));
    add_row(corner_row(1'b0, 16'h0000, 16'h0000, 1'b1, known_result(0, 1'b0, 1'b0, 2)));
    add_row(corner_row(1'b0, 16'hffff, 16'h0000, 1'b1, known_result(2, 1'b1, 1'b0, 3)));
    add_row(corner_row(1'b0, 16'h0000, 16'hffff, 1'b1, known_result(3, 1'b1, 1'b0, 4)));
    add_row(corner_row(1'b0, 16'hffff, 16'hffff, 1'b1, known_result(1, 1'b0, 1'b0, 4)));
    // same halves swapped must not match
    add_row(corner_row(1'b0, 16'h0001, 16'h0002, 1'b0, '0));
    add_row(corner_row(1'b0, 16'h0002, 16'h0001, 1'b0, '0));
    add_row(corner_row(1'b0, 16'haaaa, 16'h5555, 1'b0, '0));
    add_row(corner_row(1'b0, 16'h0002, 16'h0001, 1'b0, '0));
    // start on a pair that is already stored still lands in slot 0 as new
    add_row(corner_row(1'b1, 16'h0000, 16'h0000, 1'b1, known_result(0, 1'b1, 1'b0, 1)));
    add_row(corner_row(1'b1, 16'h0000, 16'h0000, 1'b1, known_result(0, 1'b1, 1'b0, 1)));
    add_row(corner_row(1'b0, 16'h5555, 16'haaaa, 1'b0, '0));
    // start on a fresh pair, then the same pair hits slot 0
    add_row(corner_row(1'b1, 16'h1234, 16'h4321, 1'b1, known_result(0, 1'b1, 1'b0, 1)));
    add_row(corner_row(1'b0, 16'h1234, 16'h4321, 1'b1, known_result(0, 1'b0, 1'b0, 1)));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_corner(dir_rows[r].start, dir_rows[r].pos, dir_rows[r].tc,
                  dir_rows[r].typed, dir_rows[r].res);
    end

    // random part: short meshes over small index pools so that hits are frequent
    random_sent = 0;
    first_mesh  = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      if (first_mesh || $urandom_range(0, 2) == 0) begin
        wait_drained();
      end
      quiet_mode = ($urandom_range(0, 3) == 0);
      mesh_len   = $urandom_range(4, 28);
      for (int p = 0; p < POOL_SIZE; p++) begin
        pos_pool[p] = IDX_W'($urandom);
        tc_pool[p]  = IDX_W'($urandom);
      end
      for (int k = 0; k < mesh_len; k++) begin
        // most meshes open with a start; some run on from the previous table
        if (k == 0) start = ($urandom_range(0, 4) != 0);
        else start = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 7) == 0) begin
          pos = IDX_W'($urandom);
          tc  = IDX_W'($urandom);
        end else begin
          pos = pos_pool[$urandom_range(0, POOL_SIZE - 1)];
          tc  = tc_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        send_corner(start, pos, tc, 1'b0, '0);
        random_sent++;
      end
      first_mesh = 1'b0;
    end
    quiet_mode = 1'b0;

    // drain, then watch a little longer for stray results
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch("results still pending", 0, expected_q.size());
    end

    $display("run: %0d corners over directed rows and random meshes, %0d results checked",
             corners_sent, results_seen);
    $display("run: %0d new, %0d hits, %0d overflows, %0d mismatches", new_seen, hit_seen,
             overflow_seen, errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
